// ===== rtl/afpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package afpm_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int GAIN_FRAC     = 16;

	// register indexes
	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [2:0] REG_TGT_ROLL   = 3'd2;
	localparam logic [2:0] REG_TGT_PITCH  = 3'd3;
	localparam logic [2:0] REG_AX_OFS     = 3'd4;
	localparam logic [2:0] REG_AY_OFS     = 3'd5;
	localparam logic [2:0] REG_GX_OFS     = 3'd6;
	localparam logic [2:0] REG_GY_OFS     = 3'd7;

	// shared multiplier operation request
	typedef struct packed {
		logic signed [47:0] a;
		logic signed [47:0] b;
	} mul_req_t;

endpackage
`default_nettype wire

// ===== rtl/afpm_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared signed multiplier; 48x48 operands split into 24-bit partial products,
// one product per cycle while busy; the result is ready when done is raised.
module afpm_mul
	import afpm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire mul_req_t           req,
	output logic                    done,
	output logic signed [95:0]      prod
);
	logic [47:0] ua_q, ub_q;
	logic        neg_q;
	logic [2:0]  step_q;
	logic        busy_q;
	logic [95:0] acc_q;
	logic [23:0] pa, pb;
	logic [47:0] pp;
	logic [95:0] pp_sh;

	// pick the partial product of this step
	always_comb begin
		pa = step_q[1] ? ua_q[47:24] : ua_q[23:0];
		pb = step_q[0] ? ub_q[47:24] : ub_q[23:0];
		pp = {24'd0, pa} * {24'd0, pb};
		pp_sh = {48'd0, pp} << (7'd24 * {5'd0, step_q[1]} + 7'd24 * {5'd0, step_q[0]});
	end

	// run four steps of partial products, then apply the sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd3) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= req.a[47] ? 48'(-req.a) : req.a;
			ub_q  <= req.b[47] ? 48'(-req.b) : req.b;
			neg_q <= req.a[47] ^ req.b[47];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign prod = neg_q ? -$signed(acc_q) : $signed(acc_q);

	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("multiplier done held");
	ap_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("multiplier did not start");
	ap_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("done without work");
endmodule
`default_nettype wire

// ===== rtl/attitude_filter_pi_motor_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Attitude filter with PI motor mixing.
// Input stream s_axis: one request per control tick with raw accel/gyro X/Y.
// Output stream m_axis: four motor compare values and the two filtered angles.
// Configuration: cfg_we/cfg_index/cfg_data write gains, setpoints, offsets;
// write only while idle.
// Each tick runs a sequencer over one shared multiplier, which issues and
// captures one product at a time. A tick uses 6 to 20 products: two gyro
// scalings, four filter products, and per axis outside the deadband one
// proportional and three PI terms. One tick is processed at a time:
// s_axis_tready is low while a tick is in progress or its result waits in
// the output register.
// Reset clears angles and integrators, sets motor levels to 10.0 and loads
// register defaults. A stalled receiver holds the result steady and the
// block takes no new tick until it is taken.
module attitude_filter_pi_motor_mixer
	import afpm_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// accel_x[15:0], accel_y[31:16], gyro_x[47:32], gyro_y[63:48]
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// motor1..4_compare 13 bits each [51:0], roll_angle [83:52],
	// pitch_angle [115:84], zero [119:116]
	output logic [119:0]     m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [24:0] cfg_data
);
	localparam logic signed [47:0] ONE_Q  = 48'sd1 <<< FRAC_BITS;
	localparam logic signed [47:0] FILT_K = 48'((((64'd998) << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic signed [47:0] STEP_T = 48'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic signed [47:0] LVL_MAX = 48'sd1000 <<< FRAC_BITS;
	localparam logic signed [47:0] LVL_RST = 48'sd10 <<< FRAC_BITS;
	localparam logic signed [47:0] S32MAX = 48'sd2147483647;
	localparam logic signed [47:0] S32MIN = -48'sd2147483648;
	// motor level holds 0..1000 with FRAC_BITS fraction
	localparam int LVL_W = FRAC_BITS + 10;
	// reciprocal of 131 for a 17-bit magnitude: floor(m*R>>24), corrected
	localparam logic [47:0] RECIP131 = 48'd128070;

	// sequencer states
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_GDIVX = 5'd1;
	localparam logic [4:0] ST_GDIVY = 5'd2;
	localparam logic [4:0] ST_GFIX  = 5'd3;
	localparam logic [4:0] ST_F1    = 5'd4;   // K*(angle+g*T)
	localparam logic [4:0] ST_F2    = 5'd5;   // (1-K)*a
	localparam logic [4:0] ST_ERR   = 5'd6;
	localparam logic [4:0] ST_TERM  = 5'd7;   // issue one term
	localparam logic [4:0] ST_KP    = 5'd8;
	localparam logic [4:0] ST_KI    = 5'd9;
	localparam logic [4:0] ST_LVL   = 5'd10;
	localparam logic [4:0] ST_OUT3  = 5'd11;
	localparam logic [4:0] ST_DONE  = 5'd12;
	localparam logic [4:0] ST_WAIT  = 5'd13;

	logic [4:0] st_q, ret_q;
	logic [23:0] kp_q, ki_q;
	logic signed [24:0] tr_q, tp_q;
	logic signed [15:0] axo_q, ayo_q, gxo_q, gyo_q;
	logic signed [31:0] roll_q, pitch_q;
	logic signed [31:0] integ_q [3];
	logic [LVL_W-1:0] lvl_q [4];
	logic signed [47:0] d_q [4];
	logic signed [16:0] ax_q, ay_q, gx_q, gy_q;
	logic signed [47:0] g_q [2];
	logic signed [47:0] t1_q, e_q [2], term_q;
	logic axis_q;
	logic [2:0] tsel_q;      // term index within one axis
	logic [1:0] idx_q;
	logic [12:0] cmp_q [4];

	mul_req_t mreq;
	logic mstart, mdone;
	logic signed [95:0] prod;

	afpm_mul u_mul (.clk(clk), .arst_n(arst_n), .start(mstart), .req(mreq),
		.done(mdone), .prod(prod));

	function automatic logic signed [47:0] rshr(input logic signed [95:0] p, input int n);
		logic signed [95:0] t;
		t = (p + (96'sd1 <<< (n - 1))) >>> n;
		return t[47:0];
	endfunction

	function automatic logic signed [47:0] sat32(input logic signed [47:0] v);
		if (v > S32MAX) return S32MAX;
		if (v < S32MIN) return S32MIN;
		return v;
	endfunction

	// term table per axis: target motor, integrator slot (3 = none), negate
	logic [1:0] t_mot;
	logic [1:0] t_slot;
	logic       t_neg;
	always_comb begin
		t_mot = 2'd0; t_slot = 2'd3; t_neg = 1'b0;
		if (!axis_q) begin
			case (tsel_q)
				3'd0: begin t_mot = 2'd0; t_slot = 2'd3; t_neg = 1'b0; end
				3'd1: begin t_mot = 2'd1; t_slot = 2'd0; t_neg = 1'b0; end
				3'd2: begin t_mot = 2'd2; t_slot = 2'd1; t_neg = 1'b1; end
				default: begin t_mot = 2'd3; t_slot = 2'd2; t_neg = 1'b1; end
			endcase
		end else begin
			case (tsel_q)
				3'd0: begin t_mot = 2'd3; t_slot = 2'd2; t_neg = 1'b0; end
				3'd1: begin t_mot = 2'd1; t_slot = 2'd0; t_neg = 1'b0; end
				3'd2: begin t_mot = 2'd2; t_slot = 2'd1; t_neg = 1'b1; end
				default: begin t_mot = 2'd0; t_slot = 2'd3; t_neg = 1'b1; end
			endcase
		end
	end

	logic signed [47:0] e_cur, isum, lv;
	logic signed [16:0] gsel;
	logic signed [47:0] gmag, gq;
	always_comb begin
		e_cur = t_neg ? -e_q[axis_q] : e_q[axis_q];
		isum  = sat32(48'(integ_q[t_slot]) + e_cur);
		lv    = 48'(lvl_q[idx_q]) + d_q[idx_q];
		if (lv < 0) lv = '0;
		if (lv > LVL_MAX) lv = LVL_MAX;
		gsel = axis_q ? gy_q : gx_q;
		gmag = gsel[16] ? 48'(-gsel) : 48'(gsel);
		// quotient estimate with one correction step
		gq = 48'($unsigned(prod[71:24]));
		if (gmag - gq * 48'sd131 >= 48'sd131) gq = gq + 48'sd1;
	end

	assign s_axis_tready = (st_q == ST_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= 24'd52429; ki_q <= 24'd3277;
			tr_q <= '0; tp_q <= '0;
			axo_q <= '0; ayo_q <= '0; gxo_q <= '0; gyo_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  kp_q  <= cfg_data[23:0];
				REG_INTEG_GAIN: ki_q  <= cfg_data[23:0];
				REG_TGT_ROLL:   tr_q  <= cfg_data;
				REG_TGT_PITCH:  tp_q  <= cfg_data;
				REG_AX_OFS:     axo_q <= cfg_data[15:0];
				REG_AY_OFS:     ayo_q <= cfg_data[15:0];
				REG_GX_OFS:     gxo_q <= cfg_data[15:0];
				default:        gyo_q <= cfg_data[15:0];
			endcase
		end
	end

	// multiplier request by state
	always_comb begin
		mstart = 1'b0;
		mreq.a = '0;
		mreq.b = '0;
		unique case (st_q)
			ST_GDIVX, ST_GDIVY: begin
				mreq.a = gmag; mreq.b = 48'(RECIP131);
			end
			ST_F1: begin
				mreq.a = FILT_K;
				mreq.b = (axis_q ? 48'(pitch_q) : 48'(roll_q)) + g_q[axis_q] * STEP_T;
			end
			ST_F2: begin
				mreq.a = ONE_Q - FILT_K;
				mreq.b = axis_q ? 48'(ay_q) : 48'(ax_q);
			end
			ST_KP: begin mreq.a = 48'(kp_q); mreq.b = e_cur; end
			ST_KI: begin mreq.a = 48'(ki_q); mreq.b = isum; end
			default: ;
		endcase
		if ((st_q == ST_GDIVX || st_q == ST_GDIVY || st_q == ST_F1 || st_q == ST_F2 ||
			st_q == ST_KP || st_q == ST_KI) && ret_q == ST_IDLE)
			mstart = 1'b1;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ret_q <= ST_IDLE;
			roll_q <= '0; pitch_q <= '0;
			for (int i = 0; i < 3; i++) integ_q[i] <= '0;
			for (int i = 0; i < 4; i++) lvl_q[i] <= LVL_W'(LVL_RST);
			m_axis_tvalid <= 1'b0;
			axis_q <= 1'b0; tsel_q <= '0; idx_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (s_axis_tvalid) begin
					ax_q <= (17'($signed(s_axis_tdata[15:0])) - 17'(axo_q)) / 17'sd16384;
					ay_q <= (17'($signed(s_axis_tdata[31:16])) - 17'(ayo_q)) / 17'sd16384;
					gx_q <= 17'($signed(s_axis_tdata[47:32])) - 17'(gxo_q);
					gy_q <= 17'($signed(s_axis_tdata[63:48])) - 17'(gyo_q);
					for (int i = 0; i < 4; i++) d_q[i] <= '0;
					axis_q <= 1'b0;
					st_q <= ST_GDIVX;
				end
				ST_GDIVX, ST_GDIVY: begin
					if (ret_q == ST_IDLE) ret_q <= ST_WAIT;
					else if (mdone) begin
						ret_q <= ST_IDLE;
						g_q[axis_q] <= (gsel[16] ? -gq : gq) + (axis_q ? -48'sd2 : 48'sd2);
						if (!axis_q) begin axis_q <= 1'b1; st_q <= ST_GDIVY; end
						else begin axis_q <= 1'b0; st_q <= ST_GFIX; end
					end
				end
				ST_GFIX: begin
					for (int i = 0; i < 2; i++)
						if (g_q[i] >= -48'sd1 && g_q[i] <= 48'sd1) g_q[i] <= '0;
					st_q <= ST_F1;
				end
				ST_F1: begin
					if (ret_q == ST_IDLE) ret_q <= ST_WAIT;
					else if (mdone) begin
						ret_q <= ST_IDLE; t1_q <= rshr(prod, FRAC_BITS); st_q <= ST_F2;
					end
				end
				ST_F2: begin
					if (ret_q == ST_IDLE) ret_q <= ST_WAIT;
					else if (mdone) begin
						ret_q <= ST_IDLE;
						if (!axis_q) begin
							roll_q <= 32'(sat32(t1_q + prod[47:0]));
							axis_q <= 1'b1; st_q <= ST_F1;
						end else begin
							pitch_q <= 32'(sat32(t1_q + prod[47:0]));
							axis_q <= 1'b0; st_q <= ST_ERR;
						end
					end
				end
				ST_ERR: begin
					e_q[0] <= 48'(roll_q) - 48'(tr_q);
					e_q[1] <= 48'(pitch_q) - 48'(tp_q);
					tsel_q <= '0; axis_q <= 1'b0;
					st_q <= ST_TERM;
				end
				ST_TERM: begin
					// move to the next axis after its four terms, or skip it at once if its error is within the deadband
					if (tsel_q == 3'd4 || (e_q[axis_q] < STEP_T && e_q[axis_q] > -STEP_T)) begin
						tsel_q <= '0;
						if (!axis_q) axis_q <= 1'b1;
						else begin idx_q <= '0; st_q <= ST_LVL; end
					end else st_q <= ST_KP;
				end
				ST_KP: begin
					if (ret_q == ST_IDLE) ret_q <= ST_WAIT;
					else if (mdone) begin
						ret_q <= ST_IDLE; term_q <= rshr(prod, GAIN_FRAC);
						if (t_slot == 2'd3) begin
							d_q[t_mot] <= d_q[t_mot] + rshr(prod, GAIN_FRAC);
							tsel_q <= tsel_q + 3'd1; st_q <= ST_TERM;
						end else st_q <= ST_KI;
					end
				end
				ST_KI: begin
					if (ret_q == ST_IDLE) ret_q <= ST_WAIT;
					else if (mdone) begin
						ret_q <= ST_IDLE;
						integ_q[t_slot] <= 32'(isum);
						d_q[t_mot] <= d_q[t_mot] + term_q + rshr(prod, GAIN_FRAC);
						tsel_q <= tsel_q + 3'd1; st_q <= ST_TERM;
					end
				end
				ST_LVL: begin
					lvl_q[idx_q] <= LVL_W'(lv);
					cmp_q[idx_q] <= 13'(((lv + lv + lv) >>> FRAC_BITS) + 48'sd3000);
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) st_q <= ST_OUT3;
				end
				ST_OUT3: begin m_axis_tvalid <= 1'b1; st_q <= ST_DONE; end
				ST_DONE: if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {4'd0, pitch_q, roll_q, cmp_q[3], cmp_q[2], cmp_q[1], cmp_q[0]};

	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accepted while result pending");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	ap_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> st_q == ST_GDIVX) else $error("tick not started");
endmodule
`default_nettype wire
